// ===== sv/http_chunked_body_decoder_assert.svh =====
// Assertion macros used by the decoder checker.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// Condition that must hold at every clock edge.
`define HCBD_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("hcbd: assertion failed");

// Condition that must hold in the cycle after the antecedent.
`define HCBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcbd: assertion failed");

`endif

// ===== sv/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and helpers shared by the chunked body decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

  localparam int unsigned SIZE_BITS = 32;
  localparam int unsigned TDATA_W   = 16;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [6:0] {
    PH_SIZE    = 7'b0000001,
    PH_SIZE_LF = 7'b0000010,
    PH_DATA    = 7'b0000100,
    PH_TRL_CR  = 7'b0001000,
    PH_TRL_LF  = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_ERROR   = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_NO_LINE_END = 3'd1,
    ERR_NO_DIGITS   = 3'd2,
    ERR_BODY_CUT    = 3'd3,
    ERR_TRAILER     = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    status_e    status;
    err_e       kind;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // ASCII hex digit decode; letters map through their low nibble plus 9
  function automatic hex_t hex_value(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hcbd_in_reg.sv =====
// ----------------------------------------------------------------------------
// hcbd_in_reg
// Input register with a skid entry, so tready is a plain flop.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  hcbd_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           ready_i,
  output hcbd_pkg::item_t item_o
);
  import hcbd_pkg::*;

  logic  main_vld_q, skid_vld_q;
  item_t main_q, skid_q;
  logic  accept, take;

  assign ready_o = !skid_vld_q;
  assign accept  = valid_i && ready_o;
  assign take    = main_vld_q && ready_i;
  assign valid_o = main_vld_q;
  assign item_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (accept) begin
      if (main_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        main_vld_q <= 1'b1;
      end
    end else if (take) begin
      main_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        main_q <= skid_q;
      end
    end else if (accept) begin
      if (main_vld_q && !take) begin
        skid_q <= item_i;
      end else begin
        main_q <= item_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/hcbd_core.sv =====
// ----------------------------------------------------------------------------
// hcbd_core
// Chunk framing state and the one-byte step: size line, payload, CRLF.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  hcbd_pkg::item_t   item_i,
  output hcbd_pkg::result_t result_o
);
  import hcbd_pkg::*;

  phase_e               phase_q, phase_d;
  logic [SIZE_BITS-1:0] left_q, left_d;
  logic                 digit_q, digit_d;
  logic                 skip_q, skip_d;
  logic                 ovf_q, ovf_d;
  err_e                 err_q, err_d;

  always_comb begin
    hex_t    hex;
    result_t res;
    hex        = hex_value(item_i.data);
    phase_d    = phase_q;
    left_d     = left_q;
    digit_d    = digit_q;
    skip_d     = skip_q;
    ovf_d      = ovf_q;
    err_d      = err_q;
    res.valid  = 1'b0;
    res.data   = 8'd0;
    res.status = ST_RUN;
    res.kind   = ERR_NONE;

    if (fire_i) begin
      case (phase_q)
        PH_SIZE: begin
          if (item_i.data == CH_CR) begin
            phase_d = PH_SIZE_LF;
          end else if (!skip_q && hex.ok) begin
            digit_d = 1'b1;
            // digit would carry past the counter: flag, report at LF
            if (left_q[SIZE_BITS-1 -: 4] != 4'd0) begin
              ovf_d = 1'b1;
            end else begin
              left_d = {left_q[SIZE_BITS-5:0], hex.val};
            end
          end else begin
            skip_d = 1'b1;
          end
        end
        PH_SIZE_LF: begin
          if (item_i.data == CH_LF) begin
            if (ovf_q) begin
              phase_d = PH_ERROR;
              err_d   = ERR_TRAILER;
            end else if (!digit_q) begin
              phase_d = PH_ERROR;
              err_d   = ERR_NO_DIGITS;
            end else if (left_q == '0) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_DATA;
            end
            digit_d = 1'b0;
            skip_d  = 1'b0;
            ovf_d   = 1'b0;
          end else if (item_i.data != CH_CR) begin
            // lone CR: treat as extension text
            skip_d  = 1'b1;
            phase_d = PH_SIZE;
          end
        end
        PH_DATA: begin
          res.valid = 1'b1;
          res.data  = item_i.data;
          left_d    = left_q - SIZE_BITS'(1);
          if (left_q == SIZE_BITS'(1)) begin
            phase_d = PH_TRL_CR;
          end
        end
        PH_TRL_CR: begin
          if (item_i.data == CH_CR) begin
            phase_d = PH_TRL_LF;
          end else begin
            phase_d = PH_ERROR;
            err_d   = ERR_TRAILER;
          end
        end
        PH_TRL_LF: begin
          if (item_i.data == CH_LF) begin
            phase_d = PH_SIZE;
          end else begin
            phase_d = PH_ERROR;
            err_d   = ERR_TRAILER;
          end
        end
        PH_DONE, PH_ERROR: begin
        end
        default: begin
          phase_d = PH_ERROR;
          err_d   = ERR_TRAILER;
        end
      endcase

      // body ends early
      if (item_i.last) begin
        if (phase_d == PH_SIZE || phase_d == PH_SIZE_LF) begin
          phase_d = PH_ERROR;
          err_d   = ERR_NO_LINE_END;
        end else if (phase_d == PH_DATA) begin
          phase_d = PH_ERROR;
          err_d   = ERR_BODY_CUT;
        end else if (phase_d == PH_TRL_CR || phase_d == PH_TRL_LF) begin
          phase_d = PH_ERROR;
          err_d   = ERR_TRAILER;
        end
      end

      if (phase_d == PH_DONE) begin
        res.status = ST_DONE;
      end else if (phase_d == PH_ERROR) begin
        res.status = ST_ERROR;
        res.kind   = err_d;
        res.valid  = 1'b0;
        res.data   = 8'd0;
      end

      // re-arm after the final byte
      if (item_i.last) begin
        phase_d = PH_SIZE;
        left_d  = '0;
        digit_d = 1'b0;
        skip_d  = 1'b0;
        ovf_d   = 1'b0;
        err_d   = ERR_NONE;
      end
    end
    result_o = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      left_q  <= '0;
      digit_q <= 1'b0;
      skip_q  <= 1'b0;
      ovf_q   <= 1'b0;
      err_q   <= ERR_NONE;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      digit_q <= digit_d;
      skip_q  <= skip_d;
      ovf_q   <= ovf_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hcbd_out_reg.sv =====
// ----------------------------------------------------------------------------
// hcbd_out_reg
// Result register; reloads in the cycle its request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  hcbd_pkg::result_t result_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             ready_i,
  output hcbd_pkg::result_t result_o
);
  import hcbd_pkg::*;

  logic    vld_q;
  result_t res_q;

  assign ready_o  = !vld_q || ready_i;
  assign valid_o  = vld_q;
  assign result_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// HTTP/1.1 chunked transfer decoder, one body byte in, one result out.
// ----------------------------------------------------------------------------
// Takes one body byte per clock while the output is not stalled and returns
// exactly one result per byte, passed through an input register, then a result
// register. The framing state is updated once per byte, which sets the rate of
// one byte per clock. tuser on the output marks a payload byte. Status goes
// to done on the zero-size chunk and to error with a kind code on a framing
// fault; payload bytes already passed on before an error must be dropped by the
// consumer. The byte flagged with tlast reports the final status and
// re-arms the decoder for the next body.
`default_nettype none

module http_chunked_body_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] in_byte
  input  logic                          s_axis_tlast,  // in_last
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] out_byte, [9:8] status, [12:10] error_kind, [15:13] zero
  output logic [hcbd_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tuser   // out_valid
);
  import hcbd_pkg::*;

  item_t   in_item, core_item;
  logic    core_vld, out_rdy, fire;
  result_t core_res, out_res;

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;
  assign fire         = core_vld && out_rdy;

  hcbd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (core_vld),
    .ready_i (out_rdy),
    .item_o  (core_item)
  );

  hcbd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (core_item),
    .result_o (core_res)
  );

  hcbd_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .result_i (core_res),
    .ready_o  (out_rdy),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.kind, out_res.status, out_res.data};
  assign m_axis_tuser = out_res.valid;

endmodule

`default_nettype wire

// ===== sv/hcbd_checker.sv =====
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks on the decoder result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_chunked_body_decoder_assert.svh"

module hcbd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [7:0]                    s_axis_tdata,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [hcbd_pkg::TDATA_W-1:0]  m_axis_tdata,
  input logic                          m_axis_tuser
);
  import hcbd_pkg::*;

  logic in_seen;
  assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tlast || (s_axis_tdata != 8'd0));

  // padding above error_kind stays clear
  `HCBD_ASSERT(a_pad_zero, !m_axis_tvalid || (m_axis_tdata[15:13] == 3'b000))
  // status is never the unused code
  `HCBD_ASSERT(a_status_code, !m_axis_tvalid || (m_axis_tdata[9:8] != 2'd3))
  // a payload byte comes only while the body is still running
  `HCBD_ASSERT(a_payload_running,
    !(m_axis_tvalid && m_axis_tuser) || (m_axis_tdata[12:8] == 5'd0))
  // an error kind is given exactly when the status is error
  `HCBD_ASSERT(a_kind_on_error, !m_axis_tvalid ||
    ((m_axis_tdata[9:8] == ST_ERROR) == (m_axis_tdata[12:10] != ERR_NONE)))
  // a stalled result holds
  `HCBD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready && !in_seen,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);

`default_nettype wire
